/* hw/rtl/ccirc_pkg.sv */
// Shared types and constants for the circumcircle pipeline.
// No dependencies; imported by every module under hw/rtl.
`timescale 1ns / 1ps

package ccirc_pkg;

    localparam int COORD_BITS_DEF       = 12;
    localparam int RADIUS_FRAC_BITS_DEF = 4;

    localparam int IN_W   = 12;
    localparam int OUT_W  = 32;
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;
    localparam int REM_W  = ROOT_W + 2;

    localparam logic [63:0] CENTER_Q_LIMIT = 64'd1 << 40;
    localparam logic [63:0] INT32_MAX_MAG  = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] INT32_MIN_MAG  = 64'h0000_0000_8000_0000;

    typedef struct packed {
        logic [IN_W-1:0] first_x;
        logic [IN_W-1:0] first_y;
        logic [IN_W-1:0] second_x;
        logic [IN_W-1:0] second_y;
        logic [IN_W-1:0] third_x;
        logic [IN_W-1:0] third_y;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] center_x;
        logic signed [OUT_W-1:0] center_y;
        logic [OUT_W-1:0]        radius_fixed;
        logic                    degenerate;
        logic                    saturated;
    } out_t;

endpackage

/* hw/rtl/circumcircle_from_three_points.sv */
// Circumcircle of three points: center and radius.
// Channels: s_valid/s_ready/s_data (in_t) carries three points; m_valid/m_ready/
// m_data (out_t) carries center_x, center_y, radius_fixed, degenerate, saturated.
// Every accepted transfer yields exactly one result transfer, in order.
// Pipeline stages: the one-bit-per-stage divider (3*COORD_BITS+4+RADIUS_FRAC_BITS
// stages), the 32-stage square root and ten arithmetic and output stages.
// Throughput: one transfer per cycle while the receiver does not stall; s_ready is high
// whenever the output register is empty or being taken.
// Receiver stall: with m_valid high and m_ready low the whole pipeline holds,
// s_ready drops, and nothing is lost or repeated.
// Reset: aresetn (synchronous, active low) empties the pipeline; s_ready is
// high in the first cycle after reset.
// Collinear points give a zero result with degenerate set. Centers or radii
// out of range are clipped and set saturated.
// Depends on ccirc_pkg, ccirc_front, ccirc_div, ccirc_rprep, ccirc_sqrt.
`timescale 1ns / 1ps

module circumcircle_from_three_points
    import ccirc_pkg::*;
#(
    parameter int COORD_BITS       = COORD_BITS_DEF,
    parameter int RADIUS_FRAC_BITS = RADIUS_FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int C   = COORD_BITS;
    localparam int F   = RADIUS_FRAC_BITS;
    localparam int NW  = 3 * C + 4;
    localparam int DW  = 2 * C + 2;
    localparam int QW  = NW + F;
    localparam int SW1 = 2 * C + 3;
    localparam int SW2 = 2 * OUT_W + 3;

    logic adv;

    logic          fr_valid;
    logic [NW-1:0] fr_nx, fr_ny;
    logic [DW-1:0] fr_den;
    logic          fr_negx, fr_negy, fr_degen;
    logic [C-1:0]  fr_x2, fr_y2;

    logic           dv_valid;
    logic [QW-1:0]  dv_qx, dv_qy;
    logic [SW1-1:0] dv_side;

    logic                    rp_valid;
    logic signed [OUT_W-1:0] rp_cx, rp_cy;
    logic                    rp_csat, rp_fail, rp_degen;
    logic [RAD_W-1:0]        rp_sum;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    logic [SW2-1:0]    sq_side;

    logic out_valid_reg;
    out_t out_reg, out_next;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    ccirc_front #(.C(C)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .x1        (C'(s_data.first_x)),
        .y1        (C'(s_data.first_y)),
        .x2        (C'(s_data.second_x)),
        .y2        (C'(s_data.second_y)),
        .x3        (C'(s_data.third_x)),
        .y3        (C'(s_data.third_y)),
        .out_valid (fr_valid),
        .num_x_mag (fr_nx),
        .num_y_mag (fr_ny),
        .den_mag   (fr_den),
        .neg_x     (fr_negx),
        .neg_y     (fr_negy),
        .degen     (fr_degen),
        .x2_out    (fr_x2),
        .y2_out    (fr_y2)
    );

    ccirc_div #(.NW(NW), .DW(DW), .F(F), .SW(SW1)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (fr_valid),
        .num_x     (fr_nx),
        .num_y     (fr_ny),
        .den       (fr_den),
        .side_in   ({fr_x2, fr_y2, fr_negx, fr_negy, fr_degen}),
        .out_valid (dv_valid),
        .quo_x     (dv_qx),
        .quo_y     (dv_qy),
        .side_out  (dv_side)
    );

    ccirc_rprep #(.C(C), .F(F), .QW(QW)) u_rprep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (dv_valid),
        .quo_x      (dv_qx),
        .quo_y      (dv_qy),
        .neg_x      (dv_side[2]),
        .neg_y      (dv_side[1]),
        .px         (dv_side[SW1-1:C+3]),
        .py         (dv_side[C+2:3]),
        .degen_in   (dv_side[0]),
        .out_valid  (rp_valid),
        .center_x   (rp_cx),
        .center_y   (rp_cy),
        .center_sat (rp_csat),
        .dist_fail  (rp_fail),
        .dist_sq    (rp_sum),
        .degen_out  (rp_degen)
    );

    ccirc_sqrt #(.SW(SW2)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (rp_valid),
        .radicand  (rp_sum),
        .side_in   ({rp_cx, rp_cy, rp_csat, rp_fail, rp_degen}),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // sideband: {center_x, center_y, center_sat, dist_fail, degenerate}
    always_comb begin
        if (sq_side[0]) begin
            out_next.center_x     = '0;
            out_next.center_y     = '0;
            out_next.radius_fixed = '0;
            out_next.degenerate   = 1'b1;
            out_next.saturated    = 1'b0;
        end else begin
            out_next.center_x     = $signed(sq_side[SW2-1:OUT_W+3]);
            out_next.center_y     = $signed(sq_side[OUT_W+2:3]);
            out_next.radius_fixed = sq_side[1] ? '1 : sq_root;
            out_next.degenerate   = 1'b0;
            out_next.saturated    = sq_side[2] | sq_side[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

/* hw/rtl/ccirc_front.sv */
// Front end: point differences, determinant and center numerators.
// Five register stages. Depends on ccirc_pkg.
`timescale 1ns / 1ps

module ccirc_front
    import ccirc_pkg::*;
#(
    parameter int C = COORD_BITS_DEF,
    localparam int NW = 3 * C + 4,
    localparam int DW = 2 * C + 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [C-1:0]  x1,
    input  logic [C-1:0]  y1,
    input  logic [C-1:0]  x2,
    input  logic [C-1:0]  y2,
    input  logic [C-1:0]  x3,
    input  logic [C-1:0]  y3,
    output logic          out_valid,
    output logic [NW-1:0] num_x_mag,
    output logic [NW-1:0] num_y_mag,
    output logic [DW-1:0] den_mag,
    output logic          neg_x,
    output logic          neg_y,
    output logic          degen,
    output logic [C-1:0]  x2_out,
    output logic [C-1:0]  y2_out
);

    // stage 1: input capture
    logic               v1_reg;
    logic [5:0][C-1:0]  pts_reg;

    // stage 2: differences, products, squares
    logic               v2_reg;
    logic signed [C:0]  dx12_next, dy23_next, dx23_next, dy12_next;
    logic signed [C:0]  dx12_2_reg, dy23_2_reg, dx23_2_reg, dy12_2_reg;
    logic signed [2*C+1:0] p1_next, p2_next, p1_reg, p2_reg;
    logic [5:0][2*C-1:0]   sq_next, sq_reg;
    logic [C-1:0]       x2_2_reg, y2_2_reg;

    // stage 3: determinant and norm differences
    logic               v3_reg;
    logic [2*C:0]       s1_sum, s2_sum, s3_sum;
    logic signed [2*C+2:0] det_next, det_3_reg;
    logic signed [2*C+1:0] bb_next, cc_next, bb_reg, cc_reg;
    logic signed [C:0]  dx12_3_reg, dy23_3_reg, dx23_3_reg, dy12_3_reg;
    logic [C-1:0]       x2_3_reg, y2_3_reg;

    // stage 4: numerator products
    logic               v4_reg;
    logic signed [3*C+2:0] m1_next, m2_next, m3_next, m4_next;
    logic signed [3*C+2:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [2*C+2:0] det_4_reg;
    logic [C-1:0]       x2_4_reg, y2_4_reg;

    // stage 5: numerators, magnitudes and signs
    logic               v5_reg;
    logic signed [NW-1:0]  numx, numy;
    logic signed [2*C+3:0] den_s;
    logic [NW-1:0]      nxm_next, nym_next, nxm_reg, nym_reg;
    logic [2*C+3:0]     den_abs;
    logic [DW-1:0]      den_reg;
    logic               negx_reg, negy_reg, degen_reg;
    logic [C-1:0]       x2_5_reg, y2_5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_comb begin
        dx12_next = $signed({1'b0, pts_reg[0]}) - $signed({1'b0, pts_reg[2]});
        dy23_next = $signed({1'b0, pts_reg[3]}) - $signed({1'b0, pts_reg[5]});
        dx23_next = $signed({1'b0, pts_reg[2]}) - $signed({1'b0, pts_reg[4]});
        dy12_next = $signed({1'b0, pts_reg[1]}) - $signed({1'b0, pts_reg[3]});
        p1_next   = dx12_next * dy23_next;
        p2_next   = dx23_next * dy12_next;
        for (int i = 0; i < 6; i++) begin
            sq_next[i] = (2 * C)'(pts_reg[i]) * (2 * C)'(pts_reg[i]);
        end
    end

    always_comb begin
        s1_sum   = (2 * C + 1)'(sq_reg[0]) + (2 * C + 1)'(sq_reg[1]);
        s2_sum   = (2 * C + 1)'(sq_reg[2]) + (2 * C + 1)'(sq_reg[3]);
        s3_sum   = (2 * C + 1)'(sq_reg[4]) + (2 * C + 1)'(sq_reg[5]);
        det_next = p1_reg - p2_reg;
        bb_next  = $signed({1'b0, s1_sum}) - $signed({1'b0, s2_sum});
        cc_next  = $signed({1'b0, s2_sum}) - $signed({1'b0, s3_sum});
    end

    always_comb begin
        m1_next = bb_reg * dy23_3_reg;
        m2_next = cc_reg * dy12_3_reg;
        m3_next = cc_reg * dx12_3_reg;
        m4_next = bb_reg * dx23_3_reg;
    end

    always_comb begin
        numx     = m1_reg - m2_reg;
        numy     = m3_reg - m4_reg;
        den_s    = {det_4_reg, 1'b0};
        nxm_next = numx[NW-1] ? NW'(-numx) : NW'(numx);
        nym_next = numy[NW-1] ? NW'(-numy) : NW'(numy);
        den_abs  = den_s[2*C+3] ? (2 * C + 4)'(-den_s) : (2 * C + 4)'(den_s);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pts_reg    <= {y3, x3, y2, x2, y1, x1};

            dx12_2_reg <= dx12_next;
            dy23_2_reg <= dy23_next;
            dx23_2_reg <= dx23_next;
            dy12_2_reg <= dy12_next;
            p1_reg     <= p1_next;
            p2_reg     <= p2_next;
            sq_reg     <= sq_next;
            x2_2_reg   <= pts_reg[2];
            y2_2_reg   <= pts_reg[3];

            det_3_reg  <= det_next;
            bb_reg     <= bb_next;
            cc_reg     <= cc_next;
            dx12_3_reg <= dx12_2_reg;
            dy23_3_reg <= dy23_2_reg;
            dx23_3_reg <= dx23_2_reg;
            dy12_3_reg <= dy12_2_reg;
            x2_3_reg   <= x2_2_reg;
            y2_3_reg   <= y2_2_reg;

            m1_reg     <= m1_next;
            m2_reg     <= m2_next;
            m3_reg     <= m3_next;
            m4_reg     <= m4_next;
            det_4_reg  <= det_3_reg;
            x2_4_reg   <= x2_3_reg;
            y2_4_reg   <= y2_3_reg;

            nxm_reg    <= nxm_next;
            nym_reg    <= nym_next;
            den_reg    <= den_abs[DW-1:0];
            negx_reg   <= numx[NW-1] ^ det_4_reg[2*C+2];
            negy_reg   <= numy[NW-1] ^ det_4_reg[2*C+2];
            degen_reg  <= (det_4_reg == '0);
            x2_5_reg   <= x2_4_reg;
            y2_5_reg   <= y2_4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign num_x_mag = nxm_reg;
    assign num_y_mag = nym_reg;
    assign den_mag   = den_reg;
    assign neg_x     = negx_reg;
    assign neg_y     = negy_reg;
    assign degen     = degen_reg;
    assign x2_out    = x2_5_reg;
    assign y2_out    = y2_5_reg;

endmodule

/* hw/rtl/ccirc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, two lanes
// sharing one divisor. Depends on ccirc_pkg.
`timescale 1ns / 1ps

module ccirc_div
    import ccirc_pkg::*;
#(
    parameter int NW = 3 * COORD_BITS_DEF + 4,
    parameter int DW = 2 * COORD_BITS_DEF + 2,
    parameter int F  = RADIUS_FRAC_BITS_DEF,
    parameter int SW = 2 * COORD_BITS_DEF + 3,
    localparam int QW = NW + F
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [NW-1:0] num_x,
    input  logic [NW-1:0] num_y,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo_x,
    output logic [QW-1:0] quo_y,
    output logic [SW-1:0] side_out
);

    logic          vld_reg [QW];
    logic [DW-1:0] rx_reg  [QW];
    logic [DW-1:0] ry_reg  [QW];
    logic [QW-1:0] qx_reg  [QW];
    logic [QW-1:0] qy_reg  [QW];
    logic [DW-1:0] d_reg   [QW];
    logic [SW-1:0] sb_reg  [QW];

    // remainder and dividend/quotient shift word advance by one bit
    function automatic logic [DW+QW-1:0] div_step(
        input logic [DW-1:0] r,
        input logic [QW-1:0] q,
        input logic [DW-1:0] d
    );
        logic [DW:0]   sh;
        logic [DW+1:0] diff;
        sh   = {r, q[QW-1]};
        diff = {1'b0, sh} - {2'b00, d};
        if (diff[DW+1]) begin
            return {sh[DW-1:0], q[QW-2:0], 1'b0};
        end else begin
            return {diff[DW-1:0], q[QW-2:0], 1'b1};
        end
    endfunction

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic          v_in;
        logic [DW-1:0] rx_in, ry_in, d_in;
        logic [QW-1:0] qx_in, qy_in;
        logic [SW-1:0] sb_in;
        logic [DW+QW-1:0] nx, ny;

        if (k == 0) begin : g_first
            assign v_in  = in_valid;
            assign rx_in = '0;
            assign ry_in = '0;
            assign qx_in = QW'(num_x) << F;
            assign qy_in = QW'(num_y) << F;
            assign d_in  = den;
            assign sb_in = side_in;
        end else begin : g_next
            assign v_in  = vld_reg[k-1];
            assign rx_in = rx_reg[k-1];
            assign ry_in = ry_reg[k-1];
            assign qx_in = qx_reg[k-1];
            assign qy_in = qy_reg[k-1];
            assign d_in  = d_reg[k-1];
            assign sb_in = sb_reg[k-1];
        end

        assign nx = div_step(rx_in, qx_in, d_in);
        assign ny = div_step(ry_in, qy_in, d_in);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rx_reg[k] <= nx[DW+QW-1:QW];
                qx_reg[k] <= nx[QW-1:0];
                ry_reg[k] <= ny[DW+QW-1:QW];
                qy_reg[k] <= ny[QW-1:0];
                d_reg[k]  <= d_in;
                sb_reg[k] <= sb_in;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quo_x     = qx_reg[QW-1];
    assign quo_y     = qy_reg[QW-1];
    assign side_out  = sb_reg[QW-1];

endmodule

/* hw/rtl/ccirc_rprep.sv */
// Center clipping, offset of the second point from the fixed-point center,
// and the squared distance. Four register stages. Depends on ccirc_pkg.
`timescale 1ns / 1ps

module ccirc_rprep
    import ccirc_pkg::*;
#(
    parameter int C  = COORD_BITS_DEF,
    parameter int F  = RADIUS_FRAC_BITS_DEF,
    parameter int QW = 3 * COORD_BITS_DEF + 4 + RADIUS_FRAC_BITS_DEF,
    localparam int EXW = QW + 34
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic [QW-1:0]           quo_x,
    input  logic [QW-1:0]           quo_y,
    input  logic                    neg_x,
    input  logic                    neg_y,
    input  logic [C-1:0]            px,
    input  logic [C-1:0]            py,
    input  logic                    degen_in,
    output logic                    out_valid,
    output logic signed [OUT_W-1:0] center_x,
    output logic signed [OUT_W-1:0] center_y,
    output logic                    center_sat,
    output logic                    dist_fail,
    output logic [RAD_W-1:0]        dist_sq,
    output logic                    degen_out
);

    // stage A
    logic              va_reg;
    logic [32:0]       clip_x, clip_y;
    logic [63:0]       mag_x, mag_y;
    logic signed [QW+1:0] dvx_next, dvy_next, dvx_reg, dvy_reg;
    logic [31:0]       cx_a_reg, cy_a_reg;
    logic              csat_a_reg, qfail_reg, degen_a_reg;

    // stage B
    logic              vb_reg;
    logic signed [EXW-1:0] ex_x, ex_y;
    logic [EXW-1:0]    abs_x, abs_y;
    logic [31:0]       ax_reg, ay_reg;
    logic [31:0]       cx_b_reg, cy_b_reg;
    logic              csat_b_reg, fail_b_reg, degen_b_reg;

    // stage C
    logic              vc_reg;
    logic [63:0]       sqx_reg, sqy_reg;
    logic [31:0]       cx_c_reg, cy_c_reg;
    logic              csat_c_reg, fail_c_reg, degen_c_reg;

    // stage D
    logic              vd_reg;
    logic [64:0]       sum_next;
    logic [63:0]       sum_reg;
    logic [31:0]       cx_d_reg, cy_d_reg;
    logic              csat_d_reg, fail_d_reg, degen_d_reg;

    function automatic logic [32:0] clip32(input logic [63:0] m, input logic neg);
        logic [63:0] nm;
        nm = -m;
        if (!neg && m > INT32_MAX_MAG) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (neg && m > INT32_MIN_MAG) begin
            return {1'b1, 32'h8000_0000};
        end else begin
            return {1'b0, neg ? nm[31:0] : m[31:0]};
        end
    endfunction

    // offset p*2^F minus the signed fixed-point center
    function automatic logic signed [QW+1:0] offset(
        input logic [QW-1:0] q,
        input logic          neg,
        input logic [C-1:0]  p
    );
        logic signed [QW:0] cf;
        logic [QW+1:0]      pf;
        cf = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        pf = (QW + 2)'(p) << F;
        return $signed(pf) - cf;
    endfunction

    always_comb begin
        mag_x    = 64'(quo_x >> F);
        mag_y    = 64'(quo_y >> F);
        clip_x   = clip32(mag_x, neg_x);
        clip_y   = clip32(mag_y, neg_y);
        dvx_next = offset(quo_x, neg_x, px);
        dvy_next = offset(quo_y, neg_y, py);
    end

    always_comb begin
        ex_x  = dvx_reg;
        ex_y  = dvy_reg;
        abs_x = ex_x[EXW-1] ? EXW'(-ex_x) : EXW'(ex_x);
        abs_y = ex_y[EXW-1] ? EXW'(-ex_y) : EXW'(ex_y);
    end

    assign sum_next = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cx_a_reg    <= clip_x[31:0];
            cy_a_reg    <= clip_y[31:0];
            csat_a_reg  <= clip_x[32] | clip_y[32];
            qfail_reg   <= (mag_x >= CENTER_Q_LIMIT) | (mag_y >= CENTER_Q_LIMIT);
            dvx_reg     <= dvx_next;
            dvy_reg     <= dvy_next;
            degen_a_reg <= degen_in;

            ax_reg      <= abs_x[31:0];
            ay_reg      <= abs_y[31:0];
            fail_b_reg  <= qfail_reg | (|abs_x[EXW-1:32]) | (|abs_y[EXW-1:32]);
            cx_b_reg    <= cx_a_reg;
            cy_b_reg    <= cy_a_reg;
            csat_b_reg  <= csat_a_reg;
            degen_b_reg <= degen_a_reg;

            sqx_reg     <= 64'(ax_reg) * 64'(ax_reg);
            sqy_reg     <= 64'(ay_reg) * 64'(ay_reg);
            fail_c_reg  <= fail_b_reg;
            cx_c_reg    <= cx_b_reg;
            cy_c_reg    <= cy_b_reg;
            csat_c_reg  <= csat_b_reg;
            degen_c_reg <= degen_b_reg;

            sum_reg     <= sum_next[63:0];
            fail_d_reg  <= fail_c_reg | sum_next[64];
            cx_d_reg    <= cx_c_reg;
            cy_d_reg    <= cy_c_reg;
            csat_d_reg  <= csat_c_reg;
            degen_d_reg <= degen_c_reg;
        end
    end

    assign out_valid  = vd_reg;
    assign center_x   = $signed(cx_d_reg);
    assign center_y   = $signed(cy_d_reg);
    assign center_sat = csat_d_reg;
    assign dist_fail  = fail_d_reg;
    assign dist_sq    = sum_reg;
    assign degen_out  = degen_d_reg;

endmodule

/* hw/rtl/ccirc_sqrt.sv */
// Pipelined integer square root, two radicand bits per stage, floored.
// Carries a sideband word alongside. Depends on ccirc_pkg.
`timescale 1ns / 1ps

module ccirc_sqrt
    import ccirc_pkg::*;
#(
    parameter int SW = 2 * OUT_W + 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  radicand,
    input  logic [SW-1:0]     side_in,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output logic [SW-1:0]     side_out
);

    localparam int STEPS = ROOT_W;
    localparam int STW   = REM_W + ROOT_W + RAD_W;

    logic              vld_reg  [STEPS];
    logic [REM_W-1:0]  rem_reg  [STEPS];
    logic [ROOT_W-1:0] root_reg [STEPS];
    logic [RAD_W-1:0]  rad_reg  [STEPS];
    logic [SW-1:0]     sb_reg   [STEPS];

    function automatic logic [STW-1:0] sqrt_step(
        input logic [REM_W-1:0]  r,
        input logic [ROOT_W-1:0] q,
        input logic [RAD_W-1:0]  a
    );
        logic [REM_W+1:0] cur;
        logic [REM_W+2:0] diff;
        cur  = {r, a[RAD_W-1:RAD_W-2]};
        diff = {1'b0, cur} - {3'b000, q, 2'b01};
        if (diff[REM_W+2]) begin
            return {cur[REM_W-1:0], q[ROOT_W-2:0], 1'b0, a[RAD_W-3:0], 2'b00};
        end else begin
            return {diff[REM_W-1:0], q[ROOT_W-2:0], 1'b1, a[RAD_W-3:0], 2'b00};
        end
    endfunction

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic              v_in;
        logic [REM_W-1:0]  r_in;
        logic [ROOT_W-1:0] q_in;
        logic [RAD_W-1:0]  a_in;
        logic [SW-1:0]     sb_in;
        logic [STW-1:0]    nxt;

        if (k == 0) begin : g_first
            assign v_in  = in_valid;
            assign r_in  = '0;
            assign q_in  = '0;
            assign a_in  = radicand;
            assign sb_in = side_in;
        end else begin : g_next
            assign v_in  = vld_reg[k-1];
            assign r_in  = rem_reg[k-1];
            assign q_in  = root_reg[k-1];
            assign a_in  = rad_reg[k-1];
            assign sb_in = sb_reg[k-1];
        end

        assign nxt = sqrt_step(r_in, q_in, a_in);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k]  <= nxt[STW-1:ROOT_W+RAD_W];
                root_reg[k] <= nxt[ROOT_W+RAD_W-1:RAD_W];
                rad_reg[k]  <= nxt[RAD_W-1:0];
                sb_reg[k]   <= sb_in;
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign root      = root_reg[STEPS-1];
    assign side_out  = sb_reg[STEPS-1];

endmodule

/* tb/sv/testbench.sv */
// Testbench for circumcircle_from_three_points: directed table, then random triples.
// Results are checked in order against a behavioral predictor, or a fixed expected value for some directed rows.
// Depends on ccirc_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
    import ccirc_pkg::*;

    localparam int  N_RANDOM    = 800;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_WAIT  = 120;
    localparam int  HOLD_CYCLES = 600;
    localparam int  FRAC        = RADIUS_FRAC_BITS_DEF;
    localparam longint unsigned ALL_ONES32 = 64'hFFFF_FFFF;

    localparam out_t COLLINEAR = '{center_x: 0, center_y: 0, radius_fixed: 0,
                                   degenerate: 1'b1, saturated: 1'b0};

    typedef struct {
        in_t  pts;
        bit   typed;
        out_t want;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    out_t circle_q[$];
    int   errors = 0;
    int   cycles = 0;
    int   rx_count = 0;
    bit   burst_mode = 1'b0;

    always #4 aclk = ~aclk;

    circumcircle_from_three_points uut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    function automatic in_t pt(int x1, int y1, int x2, int y2, int x3, int y3);
        in_t p;
        p.first_x  = x1[11:0];
        p.first_y  = y1[11:0];
        p.second_x = x2[11:0];
        p.second_y = y2[11:0];
        p.third_x  = x3[11:0];
        p.third_y  = y3[11:0];
        return p;
    endfunction

    function automatic int clampc(int v);
        return v < 0 ? 0 : (v > 4095 ? 4095 : v);
    endfunction

    function automatic logic [31:0] clip32(longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Offset of the second point from the center, in 2^-FRAC pixel units.
    function automatic bit axis_dist(longint num, longint den, longint p, output longint dv);
        longint q, rm, frac, cf;
        q  = num / den;
        rm = num % den;
        dv = 0;
        if (q >= (64'sd1 <<< 40) || q <= -(64'sd1 <<< 40))
            return 1'b0;
        frac = (rm * (64'sd1 <<< FRAC)) / den;
        cf   = q * (64'sd1 <<< FRAC) + frac;
        dv   = p * (64'sd1 <<< FRAC) - cf;
        return !(dv >= (64'sd1 <<< 32) || dv <= -(64'sd1 <<< 32));
    endfunction

    function automatic out_t circle_of(in_t p);
        longint x1, y1, x2, y2, x3, y3, det, bb, cc, nx, ny, den, dx, dy;
        longint unsigned ax, ay, sx, sy, sum, n, res, b;
        bit sat;
        out_t r;
        x1 = longint'(p.first_x);  y1 = longint'(p.first_y);
        x2 = longint'(p.second_x); y2 = longint'(p.second_y);
        x3 = longint'(p.third_x);  y3 = longint'(p.third_y);
        det = (x1 - x2) * (y2 - y3) - (x2 - x3) * (y1 - y2);
        if (det == 0)
            return COLLINEAR;
        sat = 1'b0;
        bb  = (x1 * x1 + y1 * y1) - (x2 * x2 + y2 * y2);
        cc  = (x2 * x2 + y2 * y2) - (x3 * x3 + y3 * y3);
        nx  = bb * (y2 - y3) - cc * (y1 - y2);
        ny  = cc * (x1 - x2) - bb * (x2 - x3);
        den = 2 * det;
        r.center_x = clip32(nx / den, sat);
        r.center_y = clip32(ny / den, sat);
        if (axis_dist(nx, den, x2, dx) && axis_dist(ny, den, y2, dy)) begin
            ax  = dx < 0 ? -dx : dx;
            ay  = dy < 0 ? -dy : dy;
            sx  = ax * ax;
            sy  = ay * ay;
            sum = sx + sy;
            if (sum < sx) begin
                res = ALL_ONES32;
                sat = 1'b1;
            end else begin
                // bitwise integer square root
                n   = sum;
                res = 0;
                b   = 64'd1 << 62;
                while (b > n)
                    b >>= 2;
                while (b != 0) begin
                    if (n >= res + b) begin
                        n   = n - (res + b);
                        res = (res >> 1) + b;
                    end else begin
                        res = res >> 1;
                    end
                    b >>= 2;
                end
                if (res > ALL_ONES32) begin
                    res = ALL_ONES32;
                    sat = 1'b1;
                end
            end
        end else begin
            res = ALL_ONES32;
            sat = 1'b1;
        end
        r.radius_fixed = res[31:0];
        r.degenerate   = 1'b0;
        r.saturated    = sat;
        return r;
    endfunction

    function automatic in_t random_triple();
        int kind, x1, y1, x2, y2, a, b;
        kind = $urandom_range(0, 9);
        x1 = $urandom_range(0, 4095);
        y1 = $urandom_range(0, 4095);
        x2 = $urandom_range(0, 4095);
        y2 = $urandom_range(0, 4095);
        case (kind)
            5, 6: begin
                return pt(x1, y1, clampc(x1 + $urandom_range(0, 30) - 15),
                          clampc(y1 + $urandom_range(0, 30) - 15),
                          clampc(x1 + $urandom_range(0, 30) - 15),
                          clampc(y1 + $urandom_range(0, 30) - 15));
            end
            7: begin
                // nearly collinear: huge circle
                return pt(x1, y1, x2, y2,
                          clampc((x1 + x2) / 2 + $urandom_range(0, 2) - 1),
                          clampc((y1 + y2) / 2 + $urandom_range(0, 2) - 1));
            end
            8: begin
                a  = $urandom_range(0, 200) - 100;
                b  = $urandom_range(0, 200) - 100;
                x1 = $urandom_range(200, 3895);
                y1 = $urandom_range(200, 3895);
                return pt(x1 - a, y1 - b, x1, y1, x1 + a, y1 + b);
            end
            9: begin
                return pt(x1, y1, x2, y2, $urandom_range(0, 1) ? x1 : x2,
                          $urandom_range(0, 1) ? y1 : y2);
            end
            default: begin
                return pt(x1, y1, x2, y2, $urandom_range(0, 4095), $urandom_range(0, 4095));
            end
        endcase
    endfunction

    function automatic int gap_len();
        if (burst_mode || $urandom_range(0, 2) != 0)
            return 0;
        return $urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result checker
    always @(posedge aclk) begin
        out_t w;
        if (aresetn && m_valid && m_ready) begin
            rx_count <= rx_count + 1;
            if (circle_q.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                w = circle_q.pop_front();
                if (m_data.center_x !== w.center_x) begin
                    $error("center_x: expected %0d, got %0d", w.center_x, m_data.center_x);
                    errors++;
                end
                if (m_data.center_y !== w.center_y) begin
                    $error("center_y: expected %0d, got %0d", w.center_y, m_data.center_y);
                    errors++;
                end
                if (m_data.radius_fixed !== w.radius_fixed) begin
                    $error("radius_fixed: expected %0d, got %0d",
                           w.radius_fixed, m_data.radius_fixed);
                    errors++;
                end
                if (m_data.degenerate !== w.degenerate) begin
                    $error("degenerate: expected %0b, got %0b", w.degenerate, m_data.degenerate);
                    errors++;
                end
                if (m_data.saturated !== w.saturated) begin
                    $error("saturated: expected %0b, got %0b", w.saturated, m_data.saturated);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure
    initial begin
        int  stall;
        bit  held;
        held = 1'b0;
        wait (aresetn);
        forever begin
            if (!held && rx_count >= 150) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = gap_len();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    // sender and run control
    initial begin
        row_t rows[$];
        row_t r;
        int   gap;
        rows.insert(rows.size(), '{pt(0, 0, 0, 0, 0, 0), 1'b1, COLLINEAR});
        rows.insert(rows.size(), '{pt(4095, 4095, 4095, 4095, 4095, 4095), 1'b1, COLLINEAR});
        rows.insert(rows.size(), '{pt(0, 0, 2048, 2048, 4095, 4095), 1'b1, COLLINEAR});
        rows.insert(rows.size(), '{pt(0, 4095, 4095, 4095, 100, 4095), 1'b1, COLLINEAR});
        rows.insert(rows.size(), '{pt(7, 9, 7, 9, 300, 20), 1'b1, COLLINEAR});
        rows.insert(rows.size(), '{pt(0, 0, 4095, 0, 0, 4095), 1'b0, COLLINEAR});
        rows.insert(rows.size(), '{pt(4095, 4095, 0, 4095, 4095, 0), 1'b0, COLLINEAR});
        rows.insert(rows.size(), '{pt(0, 0, 1, 0, 0, 1), 1'b0, COLLINEAR});
        rows.insert(rows.size(), '{pt(0, 0, 4095, 4094, 4094, 4093), 1'b0, COLLINEAR});
        rows.insert(rows.size(), '{pt(4095, 0, 0, 4094, 1, 4093), 1'b0, COLLINEAR});
        rows.insert(rows.size(), '{pt(0, 0, 4095, 1, 2048, 1), 1'b0, COLLINEAR});
        rows.insert(rows.size(), '{pt(1000, 1000, 1003, 1004, 1000, 1001), 1'b0, COLLINEAR});
        rows.insert(rows.size(), '{pt(2730, 1365, 1365, 2730, 4095, 4095), 1'b0, COLLINEAR});
        rows.insert(rows.size(), '{pt(0, 4095, 4095, 0, 2047, 2048), 1'b0, COLLINEAR});
        for (int i = 0; i < N_RANDOM; i++)
            rows.insert(rows.size(), '{random_triple(), 1'b0, COLLINEAR});

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < rows.size(); i++) begin
            r = rows[i];
            burst_mode = (i >= 300 && i < 450);
            gap = gap_len();
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_data  <= r.pts;
            do @(posedge aclk); while (!s_ready);
            circle_q.insert(circle_q.size(), r.typed ? r.want : circle_of(r.pts));
        end
        s_valid <= 1'b0;
        burst_mode = 1'b0;

        wait (circle_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
